// ===== sv/double_ended_queue_core_defines.svh =====
// Assertion macros for the double-ended queue core.
// Included by the top level; depends on nothing else.
`ifndef DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DEQ_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error("deq assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DEQ_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("deq assertion failed");

`endif

// ===== sv/deq_pkg.sv =====
// Shared constants, codes and transaction types of the double-ended queue.
// No dependencies.
`default_nettype none

package deq_pkg;

    localparam int DEPTH       = 16;
    localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int SUM_W       = IDX_W + 1;
    localparam int VALUE_W     = 32;
    localparam int KIND_W      = 3;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = VALUE_W;
    localparam int OUT_TDATA_W = ((CNT_W + VALUE_W + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_CLEAR      = 3'd4
    } t_req_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic                      valid;
        t_req_kind                 kind;
        logic signed [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        t_status                   status;
        logic [CNT_W-1:0]          count;
        logic signed [VALUE_W-1:0] popped;
    } t_rsp;

    function automatic logic [IDX_W-1:0] ring_wrap(input logic [SUM_W-1:0] pos);
        logic [SUM_W-1:0] folded;
        folded = (pos >= SUM_W'(DEPTH)) ? (pos - SUM_W'(DEPTH)) : pos;
        return folded[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/deq_ring.sv =====
// Ring storage, front pointer and entry count; computes one response per request.
// Depends on deq_pkg.
`default_nettype none

module deq_ring (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire deq_pkg::t_req i_req,
    output deq_pkg::t_rsp      o_rsp
);
    import deq_pkg::*;

    logic signed [VALUE_W-1:0] r_entries [DEPTH];
    logic [IDX_W-1:0]          r_front;
    logic [CNT_W-1:0]          r_count;
    logic [IDX_W-1:0]          n_front;
    logic [CNT_W-1:0]          n_count;

    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;
    logic             pop_en;
    t_status          status;
    logic             full;
    logic             empty;
    logic [IDX_W-1:0] front_dec;
    logic [IDX_W-1:0] front_inc;
    logic [IDX_W-1:0] back_pos;
    logic [IDX_W-1:0] last_pos;

    assign full      = (r_count == CNT_W'(DEPTH));
    assign empty     = (r_count == '0);
    assign front_dec = (r_front == '0) ? IDX_W'(DEPTH - 1) : (r_front - 1'b1);
    assign front_inc = ring_wrap(SUM_W'(r_front) + SUM_W'(1));
    assign back_pos  = ring_wrap(SUM_W'(r_front) + SUM_W'(r_count));
    assign last_pos  = ring_wrap(SUM_W'(r_front) + SUM_W'(r_count) - SUM_W'(1));

    always_comb begin
        n_front = r_front;
        n_count = r_count;
        wr_en   = 1'b0;
        wr_idx  = back_pos;
        rd_idx  = r_front;
        pop_en  = 1'b0;
        status  = ST_DONE;
        unique case (i_req.kind)
            REQ_PUSH_FRONT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    n_front = front_dec;
                    wr_idx  = front_dec;
                    wr_en   = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            REQ_PUSH_BACK: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    wr_idx  = back_pos;
                    wr_en   = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            REQ_POP_FRONT: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    rd_idx  = r_front;
                    pop_en  = 1'b1;
                    n_front = front_inc;
                    n_count = r_count - 1'b1;
                end
            end
            REQ_POP_BACK: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    rd_idx  = last_pos;
                    pop_en  = 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            REQ_CLEAR: begin
                n_front = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_req.valid) begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && wr_en) begin
            r_entries[wr_idx] <= i_req.value;
        end
    end

    assign o_rsp.status = status;
    assign o_rsp.count  = n_count;
    assign o_rsp.popped = pop_en ? r_entries[rd_idx] : '0;

endmodule

`default_nettype wire

// ===== sv/double_ended_queue_core.sv =====
// Double-ended queue core: throughput one transaction per cycle unless m_tready
// holds the result register full; the request register feeds the ring
// update, whose response is held in the result register until taken.
// Reset (synchronous, active low) empties the queue and drops any held
// transaction; stored values are not cleared and are unreachable until pushed.
// Depends on deq_pkg, deq_ring and double_ended_queue_core_defines.svh.
`default_nettype none
`include "double_ended_queue_core_defines.svh"

module double_ended_queue_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [deq_pkg::IN_TDATA_W-1:0]  s_tdata,  // push_value
    input  wire logic [deq_pkg::KIND_W-1:0]      s_tuser,  // req_type
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [deq_pkg::OUT_TDATA_W-1:0]      m_tdata,  // entry_count, popped_value, pad
    output logic [deq_pkg::STATUS_W-1:0]         m_tuser   // status
);
    import deq_pkg::*;

    logic                      r_in_valid;
    t_req_kind                 r_in_kind;
    logic signed [VALUE_W-1:0] r_in_value;
    logic                      r_out_valid;
    t_rsp                      r_rsp;

    logic advance;
    t_req req;
    t_rsp rsp;

    assign advance  = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || advance;

    // hold the request until the result register can take its response
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_kind  <= t_req_kind'(s_tuser);
            r_in_value <= s_tdata[VALUE_W-1:0];
        end
    end

    assign req.valid = advance;
    assign req.kind  = r_in_kind;
    assign req.value = r_in_value;

    deq_ring u_ring (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req),
        .o_rsp  (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_rsp <= rsp;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = OUT_TDATA_W'({r_rsp.popped, r_rsp.count});
    assign m_tuser  = r_rsp.status;

    `DEQ_ASSERT_NOW(a_full_count, i_clk, i_rst_n, r_out_valid && r_rsp.status == ST_FULL, r_rsp.count == CNT_W'(DEPTH))
    `DEQ_ASSERT_NOW(a_empty_rsp, i_clk, i_rst_n, r_out_valid && r_rsp.status == ST_EMPTY, r_rsp.count == '0 && r_rsp.popped == '0)
    `DEQ_ASSERT_NEXT(a_issue, i_clk, i_rst_n, r_in_valid && !r_out_valid, r_out_valid)

endmodule

`default_nettype wire
